[rtl/sere_pkg.sv]
// Shared types, widths and codes for the stochastic event rate engine.
// No dependencies; every other RTL file refers to it by scoped names.
`default_nettype none

package sere_pkg;

  localparam int COUNT_WIDTH     = 16;
  localparam int EVENTS_PER_CELL = 12;
  localparam int COEF_WIDTH      = 32;
  localparam int RATE_WIDTH      = 64;
  localparam int CAP_WIDTH       = 16;
  localparam int STEP_WIDTH      = 4;
  localparam int CFG_INDEX_WIDTH = 4;
  localparam int CFG_DATA_WIDTH  = 64;

  // multiplier operands carry either a count or the empty-site figure
  localparam int OPND_WIDTH = (COUNT_WIDTH > CAP_WIDTH) ? COUNT_WIDTH : CAP_WIDTH;
  localparam int PROD_WIDTH = 2 * OPND_WIDTH;
  localparam int PART_WIDTH = COEF_WIDTH + OPND_WIDTH;
  localparam int SUM_WIDTH  = COEF_WIDTH + PROD_WIDTH + 1;
  localparam int OCC_WIDTH  = (COUNT_WIDTH + 1 > CAP_WIDTH) ? COUNT_WIDTH + 1 : CAP_WIDTH;

  // event codes, in emission order
  localparam logic [STEP_WIDTH-1:0] EV_OUTMIG0      = 4'd0;
  localparam logic [STEP_WIDTH-1:0] EV_IMMIG0       = 4'd1;
  localparam logic [STEP_WIDTH-1:0] EV_DEATH0       = 4'd2;
  localparam logic [STEP_WIDTH-1:0] EV_COMPETE0     = 4'd3;
  localparam logic [STEP_WIDTH-1:0] EV_DIVIDE0      = 4'd4;
  localparam logic [STEP_WIDTH-1:0] EV_OUTMIG1      = 4'd5;
  localparam logic [STEP_WIDTH-1:0] EV_IMMIG1       = 4'd6;
  localparam logic [STEP_WIDTH-1:0] EV_DEATH1       = 4'd7;
  localparam logic [STEP_WIDTH-1:0] EV_COMPETE1     = 4'd8;
  localparam logic [STEP_WIDTH-1:0] EV_DIVIDE1      = 4'd9;
  localparam logic [STEP_WIDTH-1:0] EV_ERROR_DIVIDE = 4'd10;
  localparam logic [STEP_WIDTH-1:0] EV_CONJUGATION  = 4'd11;
  localparam logic [STEP_WIDTH-1:0] EV_FIRST        = EV_OUTMIG0;
  localparam logic [STEP_WIDTH-1:0] EV_LAST         = EV_CONJUGATION;

  // configuration register indexes
  localparam logic [CFG_INDEX_WIDTH-1:0] REG_SITE_CAPACITY  = 4'd0;
  localparam logic [CFG_INDEX_WIDTH-1:0] REG_OUTMIG_PAIR    = 4'd1;
  localparam logic [CFG_INDEX_WIDTH-1:0] REG_DEATH_PAIR     = 4'd2;
  localparam logic [CFG_INDEX_WIDTH-1:0] REG_DIVISION_PAIR  = 4'd3;
  localparam logic [CFG_INDEX_WIDTH-1:0] REG_IMMIGRATION    = 4'd4;
  localparam logic [CFG_INDEX_WIDTH-1:0] REG_COMPETITION    = 4'd5;
  localparam logic [CFG_INDEX_WIDTH-1:0] REG_ERROR_DIVISION = 4'd6;
  localparam logic [CFG_INDEX_WIDTH-1:0] REG_CONJUGATION    = 4'd7;

  typedef struct packed {
    logic [COUNT_WIDTH-1:0] count_free;
    logic [COUNT_WIDTH-1:0] count_carrier;
    logic                   last_cell;
  } in_item_t;

  typedef struct packed {
    logic [STEP_WIDTH-1:0] event_index;
    logic [RATE_WIDTH-1:0] event_rate;
    logic [RATE_WIDTH-1:0] patch_rate;
    logic [RATE_WIDTH-1:0] running_total;
    logic [RATE_WIDTH-1:0] max_patch_rate;
    logic                  overfull;
    logic                  zero_total;
    logic                  last_event;
  } out_item_t;

  typedef struct packed {
    logic [CAP_WIDTH-1:0]  site_capacity;
    logic [2*COEF_WIDTH-1:0] outmig_pair;
    logic [2*COEF_WIDTH-1:0] death_pair;
    logic [2*COEF_WIDTH-1:0] division_pair;
    logic [COEF_WIDTH-1:0] immigration_coef;
    logic [COEF_WIDTH-1:0] competition_coef;
    logic [COEF_WIDTH-1:0] error_division_coef;
    logic [COEF_WIDTH-1:0] conjugation_coef;
  } cfg_t;

  // controller to datapath
  typedef struct packed {
    logic                  load;
    logic                  issue;
    logic [STEP_WIDTH-1:0] step;
  } cmd_t;

  // datapath to controller
  typedef struct packed {
    logic advance;
  } status_t;

endpackage

`default_nettype wire

[rtl/sere_cfg.sv]
// Configuration register file of the stochastic event rate engine.
// Depends on sere_pkg for the register indexes and the cfg_t bundle.
`default_nettype none

module sere_cfg (
  input  wire logic                                  clk,
  input  wire logic                                  rst,
  input  wire logic                                  cfg_valid,
  output logic                                       cfg_ready,
  input  wire logic [sere_pkg::CFG_INDEX_WIDTH-1:0]  cfg_index,
  input  wire logic [sere_pkg::CFG_DATA_WIDTH-1:0]   cfg_data,
  output sere_pkg::cfg_t                             cfg
);

  sere_pkg::cfg_t regs;

  assign cfg_ready = 1'b1;
  assign cfg       = regs;

  always_ff @(posedge clk) begin
    if (rst) begin
      regs.site_capacity       <= sere_pkg::CAP_WIDTH'(1);
      regs.outmig_pair         <= '0;
      regs.death_pair          <= '0;
      regs.division_pair       <= '0;
      regs.immigration_coef    <= '0;
      regs.competition_coef    <= '0;
      regs.error_division_coef <= '0;
      regs.conjugation_coef    <= '0;
    end else if (cfg_valid) begin
      case (cfg_index)
        sere_pkg::REG_SITE_CAPACITY: begin
          regs.site_capacity <= cfg_data[sere_pkg::CAP_WIDTH-1:0];
        end
        sere_pkg::REG_OUTMIG_PAIR: begin
          regs.outmig_pair <= cfg_data;
        end
        sere_pkg::REG_DEATH_PAIR: begin
          regs.death_pair <= cfg_data;
        end
        sere_pkg::REG_DIVISION_PAIR: begin
          regs.division_pair <= cfg_data;
        end
        sere_pkg::REG_IMMIGRATION: begin
          regs.immigration_coef <= cfg_data[sere_pkg::COEF_WIDTH-1:0];
        end
        sere_pkg::REG_COMPETITION: begin
          regs.competition_coef <= cfg_data[sere_pkg::COEF_WIDTH-1:0];
        end
        sere_pkg::REG_ERROR_DIVISION: begin
          regs.error_division_coef <= cfg_data[sere_pkg::COEF_WIDTH-1:0];
        end
        sere_pkg::REG_CONJUGATION: begin
          regs.conjugation_coef <= cfg_data[sere_pkg::COEF_WIDTH-1:0];
        end
        default: begin
        end
      endcase
    end
  end

endmodule

`default_nettype wire

[rtl/sere_ctrl.sv]
// Sequencer of the stochastic event rate engine: takes cells, issues events.
// Depends on sere_pkg for the command and status bundles.
`default_nettype none

module sere_ctrl (
  input  wire logic                 clk,
  input  wire logic                 rst,
  input  wire logic                 in_valid,
  output logic                      in_ready,
  input  wire sere_pkg::status_t    status,
  output sere_pkg::cmd_t            cmd
);

  typedef enum logic [1:0] {
    ST_IDLE  = 2'b01,
    ST_ISSUE = 2'b10
  } state_t;

  state_t                          state, state_next;
  logic [sere_pkg::STEP_WIDTH-1:0] step, step_next;
  logic                            accept;
  logic                            issue_fire;

  assign issue_fire = (state == ST_ISSUE) && status.advance;
  // next cell may enter as the current one's final event issues
  assign in_ready   = (state == ST_IDLE) ||
                      (issue_fire && (step == sere_pkg::EV_LAST));
  assign accept     = in_valid && in_ready;

  assign cmd.load  = accept;
  assign cmd.issue = issue_fire;
  assign cmd.step  = step;

  always_comb begin
    state_next = state;
    step_next  = step;
    case (state)
      ST_IDLE: begin
        if (accept) begin
          state_next = ST_ISSUE;
          step_next  = sere_pkg::EV_FIRST;
        end
      end
      ST_ISSUE: begin
        if (issue_fire) begin
          if (step == sere_pkg::EV_LAST) begin
            step_next  = sere_pkg::EV_FIRST;
            state_next = accept ? ST_ISSUE : ST_IDLE;
          end else begin
            step_next = step + sere_pkg::STEP_WIDTH'(1);
          end
        end
      end
      default: begin
        state_next = ST_IDLE;
        step_next  = sere_pkg::EV_FIRST;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      step  <= sere_pkg::EV_FIRST;
    end else begin
      state <= state_next;
      step  <= step_next;
    end
  end

endmodule

`default_nettype wire

[rtl/sere_datapath.sv]
// Datapath of the stochastic event rate engine: cell registers, shared
// multiplier chain, patch accumulator, sweep total and maximum, output item.
// Depends on sere_pkg.
`default_nettype none

module sere_datapath (
  input  wire logic                 clk,
  input  wire logic                 rst,
  input  wire sere_pkg::cfg_t       cfg,
  input  wire sere_pkg::in_item_t   in_data,
  input  wire sere_pkg::cmd_t       cmd,
  output sere_pkg::status_t         status,
  output logic                      out_valid,
  input  wire logic                 out_ready,
  output sere_pkg::out_item_t       out_data
);

  localparam int CW  = sere_pkg::COUNT_WIDTH;
  localparam int OW  = sere_pkg::OPND_WIDTH;
  localparam int PW  = sere_pkg::PROD_WIDTH;
  localparam int PPW = sere_pkg::PART_WIDTH;
  localparam int SW  = sere_pkg::SUM_WIDTH;
  localparam int KW  = sere_pkg::COEF_WIDTH;
  localparam int RW  = sere_pkg::RATE_WIDTH;
  localparam int XW  = sere_pkg::OCC_WIDTH;
  localparam int EW  = sere_pkg::STEP_WIDTH;

  // flags that follow each event down the pipe
  typedef struct packed {
    logic [EW-1:0] index;
    logic          overfull;
    logic          last_cell;
  } tag_t;

  logic advance;

  // cell registers
  logic [CW-1:0]                  nf, nc;
  logic [sere_pkg::CAP_WIDTH-1:0] empty;
  logic                           overfull, last_cell;
  logic [XW-1:0]                  occ, cap;

  // operand selection
  logic [KW-1:0] sel_coef;
  logic [OW-1:0] sel_a, sel_b;
  logic [OW-1:0] op_nf, op_nc, op_m, op_one;

  // stage 1: count product
  logic          s1_valid;
  tag_t          s1_tag;
  logic [KW-1:0] s1_coef;
  logic [PW-1:0] s1_prod;

  // stage 2: partial products of the coefficient
  logic           s2_valid;
  tag_t           s2_tag;
  logic [PPW-1:0] s2_lo, s2_hi;

  // stage 3: event rate
  logic          s3_valid;
  tag_t          s3_tag;
  logic [RW-1:0] s3_rate;
  logic [SW-1:0] sum;

  // stage 4: patch accumulation
  logic          s4_valid;
  tag_t          s4_tag;
  logic [RW-1:0] s4_rate, s4_patch;
  logic [RW:0]   patch_sum;
  logic [RW-1:0] patch_base;

  // sweep state
  logic [RW-1:0] sweep_total, sweep_max;
  logic [RW:0]   total_sum;
  logic [RW-1:0] total_new, max_new;

  assign advance        = !out_valid || out_ready;
  assign status.advance = advance;

  assign occ = XW'(in_data.count_free) + XW'(in_data.count_carrier);
  assign cap = XW'(cfg.site_capacity);

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      nf        <= in_data.count_free;
      nc        <= in_data.count_carrier;
      last_cell <= in_data.last_cell;
      if (occ > cap) begin
        empty    <= '0;
        overfull <= 1'b1;
      end else begin
        empty    <= sere_pkg::CAP_WIDTH'(cap - occ);
        overfull <= 1'b0;
      end
    end
  end

  assign op_nf  = OW'(nf);
  assign op_nc  = OW'(nc);
  assign op_m   = OW'(empty);
  assign op_one = OW'(1);

  always_comb begin
    sel_coef = '0;
    sel_a    = '0;
    sel_b    = op_one;
    case (cmd.step)
      sere_pkg::EV_OUTMIG0: begin
        sel_coef = cfg.outmig_pair[KW-1:0];
        sel_a    = op_nf;
      end
      sere_pkg::EV_IMMIG0, sere_pkg::EV_IMMIG1: begin
        sel_coef = cfg.immigration_coef;
        sel_a    = op_m;
      end
      sere_pkg::EV_DEATH0: begin
        sel_coef = cfg.death_pair[KW-1:0];
        sel_a    = op_nf;
      end
      sere_pkg::EV_COMPETE0, sere_pkg::EV_COMPETE1: begin
        sel_coef = cfg.competition_coef;
        sel_a    = op_nf;
        sel_b    = op_nc;
      end
      sere_pkg::EV_DIVIDE0: begin
        sel_coef = cfg.division_pair[KW-1:0];
        sel_a    = op_m;
        sel_b    = op_nf;
      end
      sere_pkg::EV_OUTMIG1: begin
        sel_coef = cfg.outmig_pair[2*KW-1:KW];
        sel_a    = op_nc;
      end
      sere_pkg::EV_DEATH1: begin
        sel_coef = cfg.death_pair[2*KW-1:KW];
        sel_a    = op_nc;
      end
      sere_pkg::EV_DIVIDE1: begin
        sel_coef = cfg.division_pair[2*KW-1:KW];
        sel_a    = op_m;
        sel_b    = op_nc;
      end
      sere_pkg::EV_ERROR_DIVIDE: begin
        sel_coef = cfg.error_division_coef;
        sel_a    = op_m;
        sel_b    = op_nc;
      end
      sere_pkg::EV_CONJUGATION: begin
        sel_coef = cfg.conjugation_coef;
        sel_a    = op_nf;
        sel_b    = op_nc;
      end
      default: begin
      end
    endcase
  end

  // c*a*b is exact and saturated once; the count product never overflows
  assign sum = (SW'(s2_hi) << OW) + SW'(s2_lo);

  assign patch_base = (s3_tag.index == sere_pkg::EV_FIRST) ? '0 : s4_patch;
  assign patch_sum  = (RW + 1)'(patch_base) + (RW + 1)'(s3_rate);

  assign total_sum = (RW + 1)'(sweep_total) + (RW + 1)'(s4_patch);
  assign total_new = total_sum[RW] ? '1 : total_sum[RW-1:0];
  assign max_new   = (s4_patch > sweep_max) ? s4_patch : sweep_max;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid    <= 1'b0;
      s2_valid    <= 1'b0;
      s3_valid    <= 1'b0;
      s4_valid    <= 1'b0;
      out_valid   <= 1'b0;
      sweep_total <= '0;
      sweep_max   <= '0;
    end else if (advance) begin
      s1_valid  <= cmd.issue;
      s2_valid  <= s1_valid;
      s3_valid  <= s2_valid;
      s4_valid  <= s3_valid;
      out_valid <= s4_valid;
      if (s4_valid && (s4_tag.index == sere_pkg::EV_LAST)) begin
        sweep_total <= s4_tag.last_cell ? '0 : total_new;
        sweep_max   <= s4_tag.last_cell ? '0 : max_new;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      s1_tag.index     <= cmd.step;
      s1_tag.overfull  <= overfull;
      s1_tag.last_cell <= last_cell;
      s1_coef          <= sel_coef;
      s1_prod          <= PW'(sel_a) * PW'(sel_b);

      s2_tag <= s1_tag;
      s2_lo  <= PPW'(s1_coef) * PPW'(s1_prod[OW-1:0]);
      s2_hi  <= PPW'(s1_coef) * PPW'(s1_prod[PW-1:OW]);

      s3_tag  <= s2_tag;
      s3_rate <= (|sum[SW-1:RW]) ? '1 : sum[RW-1:0];

      // patch register only moves on a real event, so bubbles keep the sum
      if (s3_valid) begin
        s4_tag   <= s3_tag;
        s4_rate  <= s3_rate;
        s4_patch <= patch_sum[RW] ? '1 : patch_sum[RW-1:0];
      end

      if (s4_valid) begin
        out_data.event_index <= s4_tag.index;
        out_data.event_rate  <= s4_rate;
        out_data.patch_rate  <= s4_patch;
        out_data.overfull    <= s4_tag.overfull;
        if (s4_tag.index == sere_pkg::EV_LAST) begin
          out_data.running_total  <= total_new;
          out_data.max_patch_rate <= max_new;
          out_data.zero_total     <= s4_tag.last_cell && (total_new == '0);
          out_data.last_event     <= 1'b1;
        end else begin
          out_data.running_total  <= sweep_total;
          out_data.max_patch_rate <= sweep_max;
          out_data.zero_total     <= 1'b0;
          out_data.last_event     <= 1'b0;
        end
      end
    end
  end

endmodule

`default_nettype wire

[rtl/stochastic_event_rate_engine_core.sv]
// Stochastic event rate engine, top level. Each lattice cell taken on the
// input (free and carrier counts) yields twelve result items, one event rate
// each, with the running patch rate, the sweep total and maximum, and the
// overfull and zero-total flags. The sequencer issues one event a cycle, while
// the output is not stalled, into a five-stage chain (count product, two
// coefficient partial products, saturation, patch accumulation, output
// register), and the next cell is taken as the last event of the current one
// issues. A stalled output holds the whole chain. Configuration is written
// through its own port, which is always ready; the user must write it only
// while the block is idle, which the block itself does not enforce.
// Depends on sere_pkg, sere_cfg, sere_ctrl and sere_datapath.
`default_nettype none

module stochastic_event_rate_engine_core (
  input  wire logic                                 clk,
  input  wire logic                                 rst,
  input  wire logic                                 in_valid,
  output logic                                      in_ready,
  input  wire sere_pkg::in_item_t                   in_data,
  output logic                                      out_valid,
  input  wire logic                                 out_ready,
  output sere_pkg::out_item_t                       out_data,
  input  wire logic                                 cfg_valid,
  output logic                                      cfg_ready,
  input  wire logic [sere_pkg::CFG_INDEX_WIDTH-1:0] cfg_index,
  input  wire logic [sere_pkg::CFG_DATA_WIDTH-1:0]  cfg_data
);

  sere_pkg::cfg_t    cfg;
  sere_pkg::cmd_t    cmd;
  sere_pkg::status_t status;

  sere_cfg u_cfg (
    .clk       (clk),
    .rst       (rst),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cfg       (cfg)
  );

  sere_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .status   (status),
    .cmd      (cmd)
  );

  sere_datapath u_datapath (
    .clk       (clk),
    .rst       (rst),
    .cfg       (cfg),
    .in_data   (in_data),
    .cmd       (cmd),
    .status    (status),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

endmodule

`default_nettype wire

[tb/tb.sv]
// Self-checking bench for stochastic_event_rate_engine_core: lattice counts in,
// twelve event-rate items out per count item, checked against an in-bench predictor.
// Depends on sere_pkg and the RTL top level only.
module tb;
  timeunit 1ns;
  timeprecision 1ps;
  import sere_pkg::*;

  localparam int STALL_LIMIT     = 3000;
  localparam int RANDOM_PER_PASS = 65;
  localparam int HOLD_OFF_CYCLES = 150;

  class rate_scoreboard;
    cfg_t                  regs;
    logic [RATE_WIDTH-1:0] sweep_total;
    logic [RATE_WIDTH-1:0] sweep_max;
    out_item_t             pending_events[$];
    int                    errors;

    function new();
      regs = '0;
      regs.site_capacity = CAP_WIDTH'(1);
      sweep_total = '0;
      sweep_max = '0;
      errors = 0;
    endfunction

    function logic [63:0] sat_mul(logic [63:0] a, logic [63:0] b);
      logic [127:0] p;
      p = {64'd0, a} * {64'd0, b};
      return (p[127:64] != 0) ? '1 : p[63:0];
    endfunction

    function logic [63:0] sat_add(logic [63:0] a, logic [63:0] b);
      logic [64:0] s;
      s = {1'b0, a} + {1'b0, b};
      return s[64] ? '1 : s[63:0];
    endfunction

    function void apply_reg(logic [CFG_INDEX_WIDTH-1:0] idx,
                            logic [CFG_DATA_WIDTH-1:0] data);
      case (idx)
        REG_SITE_CAPACITY:  regs.site_capacity = data[CAP_WIDTH-1:0];
        REG_OUTMIG_PAIR:    regs.outmig_pair = data;
        REG_DEATH_PAIR:     regs.death_pair = data;
        REG_DIVISION_PAIR:  regs.division_pair = data;
        REG_IMMIGRATION:    regs.immigration_coef = data[COEF_WIDTH-1:0];
        REG_COMPETITION:    regs.competition_coef = data[COEF_WIDTH-1:0];
        REG_ERROR_DIVISION: regs.error_division_coef = data[COEF_WIDTH-1:0];
        REG_CONJUGATION:    regs.conjugation_coef = data[COEF_WIDTH-1:0];
        default: ;
      endcase
    endfunction

    // works out the twelve event items one count item produces
    function void note_cell(in_item_t cnt);
      logic [63:0] nf, nc, occ, empty, patch;
      logic [63:0] om0, om1, de0, de1, dv0, dv1, imm, cmp, edv, cnj;
      logic [63:0] rate [EVENTS_PER_CELL];
      logic        ov;
      out_item_t   e;
      nf = 64'(cnt.count_free);
      nc = 64'(cnt.count_carrier);
      om0 = 64'(regs.outmig_pair[31:0]);
      om1 = 64'(regs.outmig_pair[63:32]);
      de0 = 64'(regs.death_pair[31:0]);
      de1 = 64'(regs.death_pair[63:32]);
      dv0 = 64'(regs.division_pair[31:0]);
      dv1 = 64'(regs.division_pair[63:32]);
      imm = 64'(regs.immigration_coef);
      cmp = 64'(regs.competition_coef);
      edv = 64'(regs.error_division_coef);
      cnj = 64'(regs.conjugation_coef);
      occ = nf + nc;
      if (occ > 64'(regs.site_capacity)) begin
        empty = '0;
        ov = 1'b1;
      end else begin
        empty = 64'(regs.site_capacity) - occ;
        ov = 1'b0;
      end
      rate[EV_OUTMIG0]      = sat_mul(om0, nf);
      rate[EV_IMMIG0]       = sat_mul(imm, empty);
      rate[EV_DEATH0]       = sat_mul(de0, nf);
      rate[EV_COMPETE0]     = sat_mul(sat_mul(cmp, nc), nf);
      rate[EV_DIVIDE0]      = sat_mul(sat_mul(dv0, empty), nf);
      rate[EV_OUTMIG1]      = sat_mul(om1, nc);
      rate[EV_IMMIG1]       = sat_mul(imm, empty);
      rate[EV_DEATH1]       = sat_mul(de1, nc);
      rate[EV_COMPETE1]     = sat_mul(sat_mul(cmp, nf), nc);
      rate[EV_DIVIDE1]      = sat_mul(sat_mul(dv1, empty), nc);
      rate[EV_ERROR_DIVIDE] = sat_mul(sat_mul(edv, empty), nc);
      rate[EV_CONJUGATION]  = sat_mul(sat_mul(cnj, nf), nc);
      patch = '0;
      for (int s = 0; s < EVENTS_PER_CELL; s++) begin
        patch = sat_add(patch, rate[s]);
        e = '0;
        e.event_index = STEP_WIDTH'(s);
        e.event_rate = rate[s];
        e.patch_rate = patch;
        e.running_total = sweep_total;
        e.max_patch_rate = sweep_max;
        e.overfull = ov;
        if (e.event_index == EV_LAST) begin
          sweep_total = sat_add(sweep_total, patch);
          if (patch > sweep_max)
            sweep_max = patch;
          e.running_total = sweep_total;
          e.max_patch_rate = sweep_max;
          e.zero_total = cnt.last_cell && (sweep_total == '0);
          e.last_event = 1'b1;
        end
        pending_events.push_back(e);
      end
      if (cnt.last_cell) begin
        sweep_total = '0;
        sweep_max = '0;
      end
    endfunction

    function void compare_field(string name, logic [63:0] want, logic [63:0] got);
      if (want !== got) begin
        $display("%0t: %s mismatch, expected %h, got %h", $time, name, want, got);
        errors++;
      end
    endfunction

    function void check_event(out_item_t got);
      out_item_t want;
      if (pending_events.size() == 0) begin
        $display("%0t: unexpected event item %h", $time, got);
        errors++;
        return;
      end
      want = pending_events.pop_front();
      compare_field("event_index", 64'(want.event_index), 64'(got.event_index));
      compare_field("event_rate", want.event_rate, got.event_rate);
      compare_field("patch_rate", want.patch_rate, got.patch_rate);
      compare_field("running_total", want.running_total, got.running_total);
      compare_field("max_patch_rate", want.max_patch_rate, got.max_patch_rate);
      compare_field("overfull", 64'(want.overfull), 64'(got.overfull));
      compare_field("zero_total", 64'(want.zero_total), 64'(got.zero_total));
      compare_field("last_event", 64'(want.last_event), 64'(got.last_event));
    endfunction
  endclass

  logic                       clk;
  logic                       rst;
  logic                       in_valid;
  logic                       in_ready;
  in_item_t                   in_data;
  logic                       out_valid;
  logic                       out_ready;
  out_item_t                  out_data;
  logic                       cfg_valid;
  logic                       cfg_ready;
  logic [CFG_INDEX_WIDTH-1:0] cfg_index;
  logic [CFG_DATA_WIDTH-1:0]  cfg_data;

  rate_scoreboard sb;
  int send_idle_pct;
  int recv_idle_pct;
  int hold_asked;
  int hold_served;
  int hold_left;
  int stall_cycles;
  int cur_cap;

  stochastic_event_rate_engine_core uut (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  // handshake monitor and watchdog
  always @(posedge clk) begin
    if (rst) begin
      stall_cycles <= 0;
    end else begin
      if (cfg_valid && cfg_ready)
        sb.apply_reg(cfg_index, cfg_data);
      if (in_valid && in_ready)
        sb.note_cell(in_data);
      if (out_valid && out_ready)
        sb.check_event(out_data);
      if ((cfg_valid && cfg_ready) || (in_valid && in_ready) || (out_valid && out_ready)) begin
        stall_cycles <= 0;
      end else if (stall_cycles >= STALL_LIMIT) begin
        $display("%0t: no handshake for %0d cycles", $time, STALL_LIMIT);
        $display("Test completed with failures");
        $finish;
      end else begin
        stall_cycles <= stall_cycles + 1;
      end
    end
  end

  // receiver: random back-pressure, plus a long hold-off on request
  initial begin
    hold_served = 0;
    hold_left = 0;
    forever begin
      @(negedge clk);
      if (hold_asked != hold_served) begin
        hold_served = hold_asked;
        hold_left = HOLD_OFF_CYCLES;
      end
      if (hold_left > 0) begin
        out_ready = 1'b0;
        hold_left--;
      end else begin
        out_ready = ($urandom_range(0, 99) >= recv_idle_pct);
      end
    end
  end

  function automatic in_item_t site_item(int nf, int nc, bit last);
    in_item_t it;
    it.count_free = COUNT_WIDTH'(nf);
    it.count_carrier = COUNT_WIDTH'(nc);
    it.last_cell = last;
    return it;
  endfunction

  // mostly occupancy within capacity, some overfull, some anywhere in range
  function automatic in_item_t rand_site(int cap);
    int nf, nc, mode;
    mode = $urandom_range(0, 9);
    if (mode == 0) begin
      nf = $urandom_range(0, 65535);
      nc = $urandom_range(0, 65535);
    end else if (mode == 1) begin
      nf = $urandom_range(0, cap);
      nc = cap - nf + $urandom_range(1, 50);
      if (nc > 65535)
        nc = 65535;
    end else begin
      nf = $urandom_range(0, cap);
      nc = $urandom_range(0, cap - nf);
    end
    return site_item(nf, nc, $urandom_range(0, 7) == 0);
  endfunction

  function automatic logic [31:0] rand_coef();
    if ($urandom_range(0, 3) == 0)
      return $urandom;
    return $urandom_range(0, 32'h0400_0000);
  endfunction

  task automatic send_cell(in_item_t it);
    while ($urandom_range(0, 99) < send_idle_pct) begin
      in_valid = 1'b0;
      @(negedge clk);
    end
    in_valid = 1'b1;
    in_data = it;
    do @(posedge clk); while (!in_ready);
    @(negedge clk);
  endtask

  task automatic cfg_write(logic [CFG_INDEX_WIDTH-1:0] idx, logic [CFG_DATA_WIDTH-1:0] data);
    cfg_valid = 1'b1;
    cfg_index = idx;
    cfg_data = data;
    do @(posedge clk); while (!cfg_ready);
    @(negedge clk);
    cfg_valid = 1'b0;
  endtask

  task automatic wait_drained();
    in_valid = 1'b0;
    while (sb.pending_events.size() != 0)
      @(posedge clk);
    repeat (8) @(negedge clk);
  endtask

  task automatic load_random_config();
    case ($urandom_range(0, 3))
      0:       cur_cap = $urandom_range(1, 65535);
      1:       cur_cap = $urandom_range(1, 20);
      default: cur_cap = $urandom_range(1, 300);
    endcase
    // unused upper bits carry noise, the block must drop them
    cfg_write(REG_SITE_CAPACITY, {$urandom, 16'($urandom), 16'(cur_cap)});
    cfg_write(REG_OUTMIG_PAIR, {rand_coef(), rand_coef()});
    cfg_write(REG_DEATH_PAIR, {rand_coef(), rand_coef()});
    cfg_write(REG_DIVISION_PAIR, {rand_coef(), rand_coef()});
    cfg_write(REG_IMMIGRATION, {$urandom, rand_coef()});
    cfg_write(REG_COMPETITION, {$urandom, rand_coef()});
    cfg_write(REG_ERROR_DIVISION, {$urandom, rand_coef()});
    cfg_write(REG_CONJUGATION, {$urandom, rand_coef()});
  endtask

  initial begin
    sb = new();
    rst = 1'b1;
    in_valid = 1'b0;
    in_data = '0;
    out_ready = 1'b0;
    cfg_valid = 1'b0;
    cfg_index = '0;
    cfg_data = '0;
    hold_asked = 0;
    send_idle_pct = 0;
    recv_idle_pct = 0;
    cur_cap = 1;
    repeat (7) @(negedge clk);
    rst = 1'b0;

    // reset config: every rate zero, so a last cell flags a zero total
    send_cell(site_item(0, 0, 1));
    send_cell(site_item(1, 0, 0));
    send_cell(site_item(0, 1, 1));
    send_cell(site_item(1, 1, 1));
    wait_drained();

    // everything at full scale: saturating products and sums
    cfg_write(REG_SITE_CAPACITY, '1);
    cfg_write(REG_OUTMIG_PAIR, '1);
    cfg_write(REG_DEATH_PAIR, '1);
    cfg_write(REG_DIVISION_PAIR, '1);
    cfg_write(REG_IMMIGRATION, '1);
    cfg_write(REG_COMPETITION, '1);
    cfg_write(REG_ERROR_DIVISION, '1);
    cfg_write(REG_CONJUGATION, '1);
    send_cell(site_item(65535, 65535, 0));
    send_cell(site_item(0, 0, 0));
    send_cell(site_item(1, 0, 1));
    send_cell(site_item(65535, 0, 0));
    send_cell(site_item(32768, 32767, 1));
    wait_drained();

    // zero capacity; writes to unmapped indexes must change nothing
    cfg_write(REG_SITE_CAPACITY, {$urandom, $urandom} & ~64'hFFFF);
    cfg_write(CFG_INDEX_WIDTH'(8), {$urandom, $urandom});
    cfg_write(CFG_INDEX_WIDTH'(15), {$urandom, $urandom});
    send_cell(site_item(0, 0, 0));
    send_cell(site_item(1, 0, 0));
    send_cell(site_item(0, 1, 1));
    wait_drained();

    // modest rates, exactly full and one over
    cfg_write(REG_SITE_CAPACITY, 64'd200);
    cfg_write(REG_OUTMIG_PAIR, {32'h0080_0000, 32'h0100_0000});
    cfg_write(REG_DEATH_PAIR, {32'h0002_0000, 32'h0040_0000});
    cfg_write(REG_DIVISION_PAIR, {32'h0000_1234, 32'h0001_0000});
    cfg_write(REG_IMMIGRATION, 64'h0000_0000_0300_0000);
    cfg_write(REG_COMPETITION, 64'h0000_0000_0000_8000);
    cfg_write(REG_ERROR_DIVISION, 64'h0000_0000_0000_0400);
    cfg_write(REG_CONJUGATION, 64'h0000_0000_0001_0000);
    send_cell(site_item(120, 80, 0));
    send_cell(site_item(120, 81, 0));
    send_cell(site_item(0, 0, 0));
    send_cell(site_item(200, 0, 0));
    send_cell(site_item(7, 9, 0));
    send_cell(site_item(0, 200, 1));
    wait_drained();

    for (int pass = 0; pass < 6; pass++) begin
      case (pass / 2)
        0: begin
          send_idle_pct = 17;
          recv_idle_pct = 50;
        end
        1: begin
          send_idle_pct = 50;
          recv_idle_pct = 17;
        end
        default: begin
          send_idle_pct = 0;
          recv_idle_pct = 0;
        end
      endcase
      load_random_config();
      for (int i = 0; i < RANDOM_PER_PASS; i++) begin
        // long output stall while items keep coming, to back up the input
        if (pass == 0 && i == 10)
          hold_asked++;
        send_cell(rand_site(cur_cap));
      end
      wait_drained();
    end

    repeat (10) @(negedge clk);
    if (sb.errors == 0 && sb.pending_events.size() == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule
